// ===== rtl/jse_pkg.sv =====
package jse_pkg;

    // Work kinds handed from the front end to the back end.
    typedef enum logic [2:0] {
        JOB_PASS = 3'd0,  // one literal character
        JOB_ESC2 = 3'd1,  // backslash + one character
        JOB_UHEX = 3'd2,  // \uXXXX from data[15:0]
        JOB_SURR = 3'd3,  // \uXXXX\uXXXX, high half data[31:16]
        JOB_ERR  = 3'd4   // single error word
    } job_kind_t;

    typedef struct packed {
        job_kind_t   kind;
        logic [31:0] data;
    } job_t;

    localparam int QDepth = 4;
    localparam int QAw    = $clog2(QDepth);

    localparam logic [7:0] ChBslash = 8'h5C;
    localparam logic [7:0] ChQuote  = 8'h22;
    localparam logic [7:0] ChU      = 8'h75;

    // Word index within a job, 0..11.
    localparam int PosW = 4;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10)
        begin
            c = 8'h30 + {4'h0, nib};
        end
        else
        begin
            c = 8'h57 + {4'h0, nib};
        end
        return c;
    endfunction

    function automatic logic [PosW-1:0] job_last_pos(input job_kind_t kind);
        logic [PosW-1:0] p;
        case (kind)
            JOB_PASS: p = 4'd0;
            JOB_ESC2: p = 4'd1;
            JOB_UHEX: p = 4'd5;
            JOB_SURR: p = 4'd11;
            JOB_ERR:  p = 4'd0;
            default:  p = 4'd0;
        endcase
        return p;
    endfunction

endpackage

// ===== rtl/jse_front.sv =====
module jse_front
    import jse_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    input  logic       q_full,
    output logic       push,
    output job_t       push_job
);

    logic        esc_reg;
    logic [2:0]  cont_reg, cont_next;
    logic [30:0] acc_reg, acc_next;
    logic        drop_reg, drop_next;
    logic        take;
    logic [30:0] code;
    logic [2:0]  lead_cnt;
    logic [30:0] lead_acc;
    logic [7:0]  esc_letter;

    assign in_ready = !q_full;
    assign take     = in_valid && in_ready;
    assign code     = {acc_reg[24:0], in_byte[5:0]};

    // lead byte decode
    always_comb
    begin
        case (in_byte) inside
            8'b110?????:
            begin
                lead_cnt = 3'd1;
                lead_acc = {26'd0, in_byte[4:0]};
            end
            8'b1110????:
            begin
                lead_cnt = 3'd2;
                lead_acc = {27'd0, in_byte[3:0]};
            end
            8'b11110???:
            begin
                lead_cnt = 3'd3;
                lead_acc = {28'd0, in_byte[2:0]};
            end
            8'b111110??:
            begin
                lead_cnt = 3'd4;
                lead_acc = {29'd0, in_byte[1:0]};
            end
            8'b1111110?:
            begin
                lead_cnt = 3'd5;
                lead_acc = {30'd0, in_byte[0]};
            end
            default:
            begin
                lead_cnt = 3'd0;
                lead_acc = '0;
            end
        endcase
    end

    always_comb
    begin
        case (in_byte)
            8'h08:   esc_letter = 8'h62;  // b
            8'h09:   esc_letter = 8'h74;  // t
            8'h0A:   esc_letter = 8'h6E;  // n
            8'h0C:   esc_letter = 8'h66;  // f
            8'h0D:   esc_letter = 8'h72;  // r
            default: esc_letter = 8'h00;
        endcase
    end

    always_comb
    begin
        cont_next     = cont_reg;
        acc_next      = acc_reg;
        drop_next     = drop_reg;
        push          = 1'b0;
        push_job.kind = JOB_PASS;
        push_job.data = {24'd0, in_byte};
        if (take)
        begin
            if (drop_reg)
            begin
                if (in_last)
                begin
                    drop_next = 1'b0;
                end
            end
            else if (cont_reg != 3'd0)
            begin
                if (in_byte[7:6] != 2'b10 || (cont_reg != 3'd1 && in_last))
                begin
                    // bad continuation or string ends mid-sequence
                    cont_next     = '0;
                    acc_next      = '0;
                    drop_next     = !in_last;
                    push          = 1'b1;
                    push_job.kind = JOB_ERR;
                end
                else if (cont_reg == 3'd1)
                begin
                    cont_next = '0;
                    acc_next  = '0;
                    push      = 1'b1;
                    if (|code[30:16])
                    begin
                        // surrogate pair; low 10 bits of D800/DC00 are zero
                        push_job.kind = JOB_SURR;
                        push_job.data = {6'b110110, code[19:16] - 4'd1, code[15:10],
                                         6'b110111, code[9:0]};
                    end
                    else
                    begin
                        push_job.kind = JOB_UHEX;
                        push_job.data = {16'd0, code[15:0]};
                    end
                end
                else
                begin
                    cont_next = cont_reg - 3'd1;
                    acc_next  = code;
                end
            end
            else if (esc_reg && in_byte[7])
            begin
                if (lead_cnt == 3'd0 || in_last)
                begin
                    drop_next     = !in_last;
                    push          = 1'b1;
                    push_job.kind = JOB_ERR;
                end
                else
                begin
                    cont_next = lead_cnt;
                    acc_next  = lead_acc;
                end
            end
            else
            begin
                push = 1'b1;
                if (in_byte == ChQuote || in_byte == ChBslash)
                begin
                    push_job.kind = JOB_ESC2;
                end
                else if (in_byte < 8'h20)
                begin
                    if (esc_letter != 8'h00)
                    begin
                        push_job.kind = JOB_ESC2;
                        push_job.data = {24'd0, esc_letter};
                    end
                    else
                    begin
                        push_job.kind = JOB_UHEX;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg  <= 1'b0;
            cont_reg <= '0;
            acc_reg  <= '0;
            drop_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                esc_reg <= cfg_wr_data;
            end
            cont_reg <= cont_next;
            acc_reg  <= acc_next;
            drop_reg <= drop_next;
        end
    end

endmodule

// ===== rtl/jse_queue.sv =====
module jse_queue
    import jse_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic empty,
    output job_t head
);

    job_t           mem_reg [QDepth];
    logic [QAw-1:0] wr_ptr_reg;
    logic [QAw-1:0] rd_ptr_reg;
    logic [QAw:0]   count_reg;
    logic           do_push;
    logic           do_pop;

    assign full    = (count_reg == QDepth[QAw:0]);
    assign empty   = (count_reg == '0);
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/jse_back.sv =====
module jse_back
    import jse_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_empty,
    input  job_t       q_head,
    output logic       q_pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_char,
    output logic       out_error,
    output logic       out_run_end
);

    logic [PosW-1:0] pos_reg;
    logic            valid_reg;
    logic [7:0]      char_reg;
    logic            err_reg;
    logic            end_reg;
    logic            load;
    logic            at_last;
    logic [PosW-1:0] sub;
    logic [15:0]     half;
    logic [7:0]      ch;

    assign load    = !valid_reg || out_ready;
    assign at_last = (pos_reg == job_last_pos(q_head.kind));
    assign q_pop   = load && !q_empty && at_last;

    // second \u group of a pair restarts at word 6
    always_comb
    begin
        if (pos_reg >= 4'd6)
        begin
            sub  = pos_reg - 4'd6;
            half = q_head.data[15:0];
        end
        else
        begin
            sub  = pos_reg;
            half = (q_head.kind == JOB_SURR) ? q_head.data[31:16] : q_head.data[15:0];
        end
    end

    always_comb
    begin
        case (q_head.kind)
            JOB_PASS: ch = q_head.data[7:0];
            JOB_ESC2: ch = (pos_reg == 4'd0) ? ChBslash : q_head.data[7:0];
            JOB_UHEX, JOB_SURR:
            begin
                case (sub)
                    4'd0:    ch = ChBslash;
                    4'd1:    ch = ChU;
                    4'd2:    ch = hex_char(half[15:12]);
                    4'd3:    ch = hex_char(half[11:8]);
                    4'd4:    ch = hex_char(half[7:4]);
                    default: ch = hex_char(half[3:0]);
                endcase
            end
            JOB_ERR:  ch = 8'h00;
            default:  ch = 8'h00;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pos_reg   <= '0;
        end
        else if (load)
        begin
            valid_reg <= !q_empty;
            if (!q_empty)
            begin
                pos_reg <= at_last ? '0 : pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && !q_empty)
        begin
            char_reg <= ch;
            err_reg  <= (q_head.kind == JOB_ERR);
            end_reg  <= at_last;
        end
    end

    assign out_valid   = valid_reg;
    assign out_char    = char_reg;
    assign out_error   = err_reg;
    assign out_run_end = end_reg;

endmodule

// ===== rtl/json_string_escaper.sv =====
// JSON string escaper: one string byte in, its escaped characters out.
// The first word of a byte passes through the job queue, then the output register.
// Throughput: one byte per ready cycle while each byte yields one word; a byte that
// escapes yields 2, 6 or 12 words, sent one per ready cycle by the output register.
// Reset (rst_n, async, active low) clears the decoder state, queue and output valid,
// and sets escape_non_ascii to 0.
module json_string_escaper
    import jse_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    // configuration: escape_non_ascii
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    // input words
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,   // in_last: final byte of a string
    // output words
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_char
    output logic       m_axis_tuser,   // [0] out_error
    output logic       m_axis_tlast    // out_run_end: last word for one input byte
);

    // Front end: UTF-8 decode and classification into one job per byte
    // (or none for dropped bytes and unfinished sequences).
    // Queue: four jobs of slack so the two sides stall independently.
    // Back end: expands a job into words into the output register.

    logic q_push;
    job_t q_push_job;
    logic q_full;
    logic q_pop;
    logic q_empty;
    job_t q_head;

    jse_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_byte     (s_axis_tdata),
        .in_last     (s_axis_tlast),
        .q_full      (q_full),
        .push        (q_push),
        .push_job    (q_push_job)
    );

    jse_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_push_job),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    jse_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_char    (m_axis_tdata),
        .out_error   (m_axis_tuser),
        .out_run_end (m_axis_tlast)
    );

endmodule

// ===== rtl/jse_checker.sv =====
module jse_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tuser,
    input logic       m_axis_tlast
);

    // stalled word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("output word changed while stalled");

    // error word is a lone zero char ending its run
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 8'h00 && m_axis_tlast)
        else $error("malformed error word");

    // control characters never leave unescaped
    a_ctrl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata >= 8'h20)
        else $error("raw control character on output");

endmodule

bind json_string_escaper jse_checker u_jse_checker (.*);
